// ===== src/psev_pkg.sv =====
// Shared types, codes and constants of the postfix stack evaluator.
package psev_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned TOKEN_W         = 32;
  localparam int unsigned HALF_W          = DATA_W / 2;

  localparam logic [TOKEN_W-1:0] TOK_PUSH_X   = 32'd14;
  localparam logic [TOKEN_W-1:0] TOK_LIT_BASE = 32'd15;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_EQ  = 4'd5,
    OP_NE  = 4'd6,
    OP_LT  = 4'd7,
    OP_GT  = 4'd8,
    OP_LE  = 4'd9,
    OP_GE  = 4'd10,
    OP_AND = 4'd11,
    OP_OR  = 4'd12,
    OP_XOR = 4'd13
  } op_e;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_DIV_ZERO  = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } cell_ctrl_t;

endpackage

// ===== src/psev_stream_if.sv =====
// Token and result stream interfaces of the postfix stack evaluator.
interface psev_in_if;
  logic                              valid;
  logic                              ready;
  logic [psev_pkg::TOKEN_W-1:0]      func;
  logic [psev_pkg::TOKEN_W-1:0]      x_value;
  logic                              last_token;

  modport source (output valid, output func, output x_value, output last_token, input ready);
  modport sink   (input valid, input func, input x_value, input last_token, output ready);
endinterface

interface psev_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [psev_pkg::DATA_W-1:0] value;
  logic [1:0]                         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== src/psev_cell.sv =====
// One stack entry of the shift-register stack; top of stack is cell 0.
module psev_cell (
  input  logic                          clk_i,
  input  psev_pkg::cell_ctrl_t          ctrl_i,
  input  logic [psev_pkg::DATA_W-1:0]   from_up_i,
  input  logic [psev_pkg::DATA_W-1:0]   from_dn_i,
  output logic [psev_pkg::DATA_W-1:0]   entry_o
);

  logic [psev_pkg::DATA_W-1:0] entry_q;
  logic [psev_pkg::DATA_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      entry_d = from_up_i;
    end else if (ctrl_i.shift_out) begin
      entry_d = from_dn_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/psev_alu.sv =====
// Multi-cycle unit: 64-bit multiply on one 32x32 multiplier, iterative signed divide/remainder.
module psev_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  psev_pkg::op_e                 op_i,
  input  logic [psev_pkg::DATA_W-1:0]   a_i,
  input  logic [psev_pkg::DATA_W-1:0]   b_i,
  output logic                          done_o,
  output logic [psev_pkg::DATA_W-1:0]   result_o
);

  localparam int unsigned DW = psev_pkg::DATA_W;
  localparam int unsigned HW = psev_pkg::HALF_W;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_DONE = 4'b1000
  } alu_state_e;

  alu_state_e          state_q, state_d;
  logic [5:0]          cnt_q, cnt_d;
  psev_pkg::op_e       op_q;
  logic [DW-1:0]       a_q, b_q;
  logic [DW-1:0]       prod_q, acc_q;
  logic [DW-1:0]       rem_q, quo_q, ub_q;
  logic                neg_quo_q, neg_rem_q;
  logic [HW-1:0]       mul_x, mul_y;
  logic [DW:0]         trial, diff;
  logic                a_neg, b_neg;

  assign a_neg = a_i[DW-1];
  assign b_neg = b_i[DW-1];

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin mul_x = a_q[HW-1:0];  mul_y = b_q[HW-1:0];  end
      2'd1:    begin mul_x = a_q[DW-1:HW]; mul_y = b_q[HW-1:0];  end
      2'd2:    begin mul_x = a_q[HW-1:0];  mul_y = b_q[DW-1:HW]; end
      default: begin mul_x = a_q[HW-1:0];  mul_y = b_q[HW-1:0];  end
    endcase
  end

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, ub_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          cnt_d   = '0;
          state_d = (op_i == psev_pkg::OP_MUL) ? A_MUL : A_DIV;
        end
      end
      A_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = A_DONE;
        end
      end
      A_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = A_DONE;
        end
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == A_IDLE && start_i) begin
      op_q      <= op_i;
      a_q       <= a_i;
      b_q       <= b_i;
      rem_q     <= '0;
      quo_q     <= a_neg ? (DW'(0) - a_i) : a_i;
      ub_q      <= b_neg ? (DW'(0) - b_i) : b_i;
      neg_quo_q <= a_neg ^ b_neg;
      neg_rem_q <= a_neg;
    end
    if (state_q == A_MUL) begin
      prod_q <= mul_x * mul_y;
      case (cnt_q[1:0])
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
        2'd3:    acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
        default: acc_q <= acc_q;
      endcase
    end
    if (state_q == A_DIV) begin
      if (!diff[DW]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (op_q)
      psev_pkg::OP_MUL: result_o = acc_q;
      psev_pkg::OP_DIV: result_o = neg_quo_q ? (DW'(0) - quo_q) : quo_q;
      psev_pkg::OP_REM: result_o = neg_rem_q ? (DW'(0) - rem_q) : rem_q;
      default:          result_o = acc_q;
    endcase
  end

  assign done_o = (state_q == A_DONE);

endmodule

// ===== src/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator: token decode, stack chain, result register.
// Usage:
//   in_i carries one postfix token per transaction (func, x_value, last_token).
//   func 15 and above pushes func-15, 14 pushes x_value, 0..13 apply a binary
//   operator to the top two entries. 64-bit wrapping arithmetic.
//   out_o carries one transaction (value, status) per program, on the token
//   marked last_token; value is 0 whenever status is not ok.
// Throughput and timing:
//   Pushes and operators other than multiply, divide and remainder take one
//   token per cycle while no result is held and not being taken. Multiply
//   forms its partial products in turn on the single 32x32 multiplier; divide
//   and remainder use the 64-step restoring divider. A result appears in out_o
//   in the cycle after its last token is accepted or the multi-cycle operator finishes.
// Reset:
//   Clears the stack count, the sticky error and the output valid. Stack cells
//   hold no reset value; only written entries are ever read.
// Stall:
//   The result stays in the output register until taken; in_i.ready drops
//   while an operator is in progress or a result is held and not being taken.
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psev_in_if.sink    in_i,
  psev_out_if.source out_o
);

  localparam int unsigned DW   = psev_pkg::DATA_W;
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } top_state_e;

  top_state_e            state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [1:0]            err_q, err_d;
  logic [DW-1:0]         bottom_q, bottom_d;
  logic                  last_q;
  logic                  out_valid_q;
  logic signed [DW-1:0]  out_value_q;
  logic [1:0]            out_status_q;

  logic                  in_acc, push, combine, start, emit;
  logic [DW-1:0]         new_val, simple_res, alu_res;
  logic                  alu_done;
  psev_pkg::op_e         op;
  logic [DW-1:0]         entry [STACK_DEPTH];
  psev_pkg::cell_ctrl_t  ctrl  [STACK_DEPTH];

  assign op       = psev_pkg::op_e'(in_i.func[3:0]);
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_i.ready;

  always_comb begin
    logic signed [DW-1:0] sa, sb;
    sa = entry[1];
    sb = entry[0];
    case (op)
      psev_pkg::OP_ADD: simple_res = entry[1] + entry[0];
      psev_pkg::OP_SUB: simple_res = entry[1] - entry[0];
      psev_pkg::OP_EQ:  simple_res = DW'(entry[1] == entry[0]);
      psev_pkg::OP_NE:  simple_res = DW'(entry[1] != entry[0]);
      psev_pkg::OP_LT:  simple_res = DW'(sa < sb);
      psev_pkg::OP_GT:  simple_res = DW'(sa > sb);
      psev_pkg::OP_LE:  simple_res = DW'(sa <= sb);
      psev_pkg::OP_GE:  simple_res = DW'(sa >= sb);
      psev_pkg::OP_AND: simple_res = DW'((|entry[1]) && (|entry[0]));
      psev_pkg::OP_OR:  simple_res = DW'((|entry[1]) || (|entry[0]));
      psev_pkg::OP_XOR: simple_res = DW'((|entry[1]) ^ (|entry[0]));
      default:          simple_res = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    err_d    = err_q;
    bottom_d = bottom_q;
    push     = 1'b0;
    combine  = 1'b0;
    start    = 1'b0;
    emit     = 1'b0;
    new_val  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (err_q == psev_pkg::STATUS_OK) begin
            if (in_i.func >= psev_pkg::TOK_LIT_BASE || in_i.func == psev_pkg::TOK_PUSH_X) begin
              if (count_q == CntW'(STACK_DEPTH)) begin
                err_d = psev_pkg::STATUS_OVERFLOW;
              end else begin
                push    = 1'b1;
                new_val = (in_i.func == psev_pkg::TOK_PUSH_X) ?
                          {32'd0, in_i.x_value} :
                          {32'd0, in_i.func - psev_pkg::TOK_LIT_BASE};
                count_d = count_q + CntW'(1);
                if (count_q == '0) begin
                  bottom_d = new_val;
                end
              end
            end else if (count_q < CntW'(2)) begin
              err_d = psev_pkg::STATUS_UNDERFLOW;
            end else if ((op == psev_pkg::OP_DIV || op == psev_pkg::OP_REM) &&
                         entry[0] == '0) begin
              err_d = psev_pkg::STATUS_DIV_ZERO;
            end else if (op == psev_pkg::OP_MUL || op == psev_pkg::OP_DIV ||
                         op == psev_pkg::OP_REM) begin
              start   = 1'b1;
              state_d = S_BUSY;
            end else begin
              combine = 1'b1;
              new_val = simple_res;
              count_d = count_q - CntW'(1);
              if (count_q == CntW'(2)) begin
                bottom_d = simple_res;
              end
            end
          end
          emit = in_i.last_token && !start;
        end
      end
      S_BUSY: begin
        if (alu_done) begin
          combine = 1'b1;
          new_val = alu_res;
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(2)) begin
            bottom_d = alu_res;
          end
          state_d = S_IDLE;
          emit    = last_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= psev_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        count_q <= '0;
        err_q   <= psev_pkg::STATUS_OK;
      end else begin
        count_q <= count_d;
        err_q   <= err_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bottom_q <= bottom_d;
    if (start) begin
      last_q <= in_i.last_token;
    end
    if (emit) begin
      out_status_q <= err_d;
      out_value_q  <= (err_d != psev_pkg::STATUS_OK || count_d == '0) ? '0 : bottom_d;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DW-1:0] from_up, from_dn;
    if (i == 0) begin : g_top
      assign ctrl[i]  = '{shift_in: push || combine, shift_out: 1'b0};
      assign from_up  = new_val;
    end else begin : g_below
      assign ctrl[i]  = '{shift_in: push, shift_out: combine};
      assign from_up  = entry[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign from_dn = '0;
    end else begin : g_mid
      assign from_dn = entry[i+1];
    end
    psev_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .from_up_i (from_up),
      .from_dn_i (from_dn),
      .entry_o   (entry[i])
    );
  end

  psev_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op),
    .a_i      (entry[1]),
    .b_i      (entry[0]),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BUSY |-> !in_i.ready)
    else $error("token accepted during multi-cycle operator");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != psev_pkg::STATUS_OK |-> out_value_q == '0)
    else $error("nonzero value with error status");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> count_q == '0 && err_q == psev_pkg::STATUS_OK && out_valid_q)
    else $error("stack not cleared after result");

  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BUSY |-> !out_valid_q)
    else $error("result pending during multi-cycle operator");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the postfix stack evaluator: directed and random programs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = psev_pkg::STACK_DEPTH_DEF;
  localparam int unsigned DW    = psev_pkg::DATA_W;
  localparam int unsigned TW    = psev_pkg::TOKEN_W;
  localparam int unsigned LIMIT = 500000;

  class postfix_checker;
    logic [DW-1:0]     stack_q [DEPTH];
    int unsigned       depth;
    logic [1:0]        err;
    logic [DW-1:0]     pending_value [$];
    logic [1:0]        pending_status [$];
    int                mismatches;
    int                programs;
    int                results;
    int                status_seen [4];

    function new();
      depth = 0;
      err = psev_pkg::STATUS_OK;
      mismatches = 0;
      programs = 0;
      results = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void push_entry(logic [DW-1:0] v);
      if (depth >= DEPTH) begin
        err = psev_pkg::STATUS_OVERFLOW;
        return;
      end
      stack_q[depth] = v;
      depth++;
    endfunction

    function void apply_operator(psev_pkg::op_e op);
      logic [DW-1:0] a, b, r, ua, ub, q;
      if (depth < 2) begin
        err = psev_pkg::STATUS_UNDERFLOW;
        return;
      end
      a = stack_q[depth-2];
      b = stack_q[depth-1];
      r = '0;
      case (op)
        psev_pkg::OP_ADD: r = a + b;
        psev_pkg::OP_SUB: r = a - b;
        psev_pkg::OP_MUL: r = a * b;
        psev_pkg::OP_DIV, psev_pkg::OP_REM: begin
          if (b == '0) begin
            err = psev_pkg::STATUS_DIV_ZERO;
            return;
          end
          ua = a[DW-1] ? -a : a;
          ub = b[DW-1] ? -b : b;
          if (op == psev_pkg::OP_DIV) begin
            q = ua / ub;
            r = (a[DW-1] ^ b[DW-1]) ? -q : q;
          end else begin
            q = ua % ub;
            r = a[DW-1] ? -q : q;
          end
        end
        psev_pkg::OP_EQ:  r = {63'd0, a == b};
        psev_pkg::OP_NE:  r = {63'd0, a != b};
        psev_pkg::OP_LT:  r = {63'd0, $signed(a) < $signed(b)};
        psev_pkg::OP_GT:  r = {63'd0, $signed(a) > $signed(b)};
        psev_pkg::OP_LE:  r = {63'd0, $signed(a) <= $signed(b)};
        psev_pkg::OP_GE:  r = {63'd0, $signed(a) >= $signed(b)};
        psev_pkg::OP_AND: r = {63'd0, (a != '0) && (b != '0)};
        psev_pkg::OP_OR:  r = {63'd0, (a != '0) || (b != '0)};
        psev_pkg::OP_XOR: r = {63'd0, (a != '0) != (b != '0)};
        default: r = '0;
      endcase
      depth--;
      stack_q[depth-1] = r;
    endfunction

    function void note_token(logic [TW-1:0] func, logic [TW-1:0] x, logic last);
      if (err == psev_pkg::STATUS_OK) begin
        if (func >= psev_pkg::TOK_LIT_BASE) push_entry({32'd0, func - psev_pkg::TOK_LIT_BASE});
        else if (func == psev_pkg::TOK_PUSH_X) push_entry({32'd0, x});
        else apply_operator(psev_pkg::op_e'(func[3:0]));
      end
      if (last) begin
        pending_value.insert(pending_value.size(),
                             (err != psev_pkg::STATUS_OK || depth == 0) ? '0 : stack_q[0]);
        pending_status.insert(pending_status.size(), err);
        depth = 0;
        err = psev_pkg::STATUS_OK;
        programs++;
      end
    endfunction

    task check_result(logic [DW-1:0] value, logic [1:0] status);
      logic [DW-1:0]     want_value;
      logic [1:0]        want_status;
      results++;
      if (pending_value.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d", value, status));
        return;
      end
      want_value = pending_value.pop_front();
      want_status = pending_status.pop_front();
      status_seen[want_status]++;
      if (status !== want_status)
        report_mismatch($sformatf("status %0d, want %0d", status, want_status));
      if (value !== want_value)
        report_mismatch($sformatf("value %h, want %h", value, want_value));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  psev_in_if  in_if ();
  psev_out_if out_if ();

  postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  postfix_checker checker_h = new();

  int unsigned cycles = 0;
  int          tokens_sent = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  bit          hold_req = 1'b0;
  bit          hold_used = 1'b0;
  int          hold_left = 0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        checker_h.note_token(in_if.func, in_if.x_value, in_if.last_token);
      if (out_if.valid && out_if.ready)
        checker_h.check_result(out_if.value, out_if.status);
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = !(rcv_idle != 0 && $urandom_range(1, 100) <= rcv_idle);
      end
    end
  end

  task automatic send_token(input logic [TW-1:0] func, input logic [TW-1:0] x,
                            input logic last);
    @(negedge clk_i);
    while (snd_idle != 0 && $urandom_range(1, 100) <= snd_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.func = func;
    in_if.x_value = x;
    in_if.last_token = last;
    do @(posedge clk_i); while (!in_if.ready);
    tokens_sent++;
  endtask

  function automatic logic [TW-1:0] random_operand();
    logic [TW-1:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return psev_pkg::TOK_LIT_BASE + $urandom_range(0, 10);
      4, 5:       return psev_pkg::TOK_PUSH_X;
      6:          return psev_pkg::TOK_LIT_BASE;
      7:          return 32'hFFFF_FFFF;
      default: begin
        t = $urandom;
        return (t < psev_pkg::TOK_LIT_BASE) ? psev_pkg::TOK_LIT_BASE : t;
      end
    endcase
  endfunction

  task automatic run_random_program();
    logic [TW-1:0] x;
    logic [TW-1:0] toks [$];
    int pushes_left, depth, len;
    case ($urandom_range(0, 6))
      0:       x = '0;
      1:       x = 32'hFFFF_FFFF;
      default: x = $urandom;
    endcase
    if ($urandom_range(0, 99) < 85) begin
      // well-formed: never underflows, stays within the stack
      pushes_left = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, DEPTH);
      depth = 0;
      while (pushes_left > 0 || depth > 1) begin
        if (depth < 2 || (pushes_left > 0 && $urandom_range(0, 1) == 1)) begin
          toks.insert(toks.size(), random_operand());
          depth++;
          pushes_left--;
        end else begin
          toks.insert(toks.size(), TW'($urandom_range(psev_pkg::OP_ADD, psev_pkg::OP_XOR)));
          depth--;
        end
      end
    end else if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(DEPTH - 1, DEPTH + 4);
      repeat (len) toks.insert(toks.size(), random_operand());
    end else begin
      len = $urandom_range(1, 12);
      repeat (len)
        toks.insert(toks.size(),
                    $urandom_range(0, 1) ? random_operand()
                      : TW'($urandom_range(psev_pkg::OP_ADD, psev_pkg::OP_XOR)));
    end
    foreach (toks[i]) send_token(toks[i], x, i == toks.size() - 1);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.x_value = '0;
    in_if.last_token = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    snd_idle = 19;
    rcv_idle = 45;

    // operator on an empty stack
    send_token(TW'(psev_pkg::OP_ADD), '0, 1'b1);
    // remainder by zero
    send_token(psev_pkg::TOK_LIT_BASE + 7, 32'hFFFF_FFFF, 1'b0);
    send_token(psev_pkg::TOK_LIT_BASE, 32'hFFFF_FFFF, 1'b0);
    send_token(TW'(psev_pkg::OP_REM), 32'hFFFF_FFFF, 1'b1);
    // most negative value divided by minus one
    send_token(psev_pkg::TOK_PUSH_X, 32'h8000_0000, 1'b0);
    send_token(psev_pkg::TOK_PUSH_X, 32'h8000_0000, 1'b0);
    send_token(TW'(psev_pkg::OP_MUL), 32'h8000_0000, 1'b0);
    send_token(psev_pkg::TOK_LIT_BASE + 2, 32'h8000_0000, 1'b0);
    send_token(TW'(psev_pkg::OP_MUL), 32'h8000_0000, 1'b0);
    send_token(psev_pkg::TOK_LIT_BASE, 32'h8000_0000, 1'b0);
    send_token(psev_pkg::TOK_LIT_BASE + 1, 32'h8000_0000, 1'b0);
    send_token(TW'(psev_pkg::OP_SUB), 32'h8000_0000, 1'b0);
    send_token(TW'(psev_pkg::OP_DIV), 32'h8000_0000, 1'b1);
    // stack overflow with the largest operands, then a token ignored by the sticky error
    for (int i = 0; i <= DEPTH; i++)
      send_token((i % 2) ? psev_pkg::TOK_PUSH_X : 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_token(TW'(psev_pkg::OP_SUB), 32'hFFFF_FFFF, 1'b1);

    while (tokens_sent < 300) run_random_program();
    snd_idle = 45;
    rcv_idle = 19;
    while (tokens_sent < 600) run_random_program();
    snd_idle = 0;
    rcv_idle = 0;
    hold_req = 1'b1;
    while (tokens_sent < 900) run_random_program();

    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (checker_h.pending_value.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("%0d tokens in %0d programs, %0d results checked, %0d mismatches",
             tokens_sent, checker_h.programs, checker_h.results, checker_h.mismatches);
    $display("status mix: ok %0d, underflow %0d, divide by zero %0d, overflow %0d",
             checker_h.status_seen[psev_pkg::STATUS_OK],
             checker_h.status_seen[psev_pkg::STATUS_UNDERFLOW],
             checker_h.status_seen[psev_pkg::STATUS_DIV_ZERO],
             checker_h.status_seen[psev_pkg::STATUS_OVERFLOW]);
    if (checker_h.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/psev_pkg.sv
src/psev_stream_if.sv
src/psev_cell.sv
src/psev_alu.sv
src/postfix_stack_evaluator.sv
tb/sv/tb.sv
